### hw/rtl/wct_pkg.sv
// wct_pkg: shared constants, beat layouts and register codes for the waypoint
// cubic trajectory block and its port checker
// no dependencies
package wct_pkg;

    localparam int MAX_SEGMENTS = 8;
    localparam int SEG_LIMIT    = (MAX_SEGMENTS < 8) ? MAX_SEGMENTS : 8;
    localparam int SEG_IDX_W    = (SEG_LIMIT > 1) ? $clog2(SEG_LIMIT) : 1;
    localparam int PIPE_DEPTH   = 8;

    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 168;
    localparam int CFG_DATA_W  = 32;

    localparam logic [16:0] S_ONE   = 17'd65536;
    localparam logic [17:0] H_THREE = 18'd196608;

    typedef enum logic [1:0] {
        CFG_START_X         = 2'd0,
        CFG_START_Y         = 2'd1,
        CFG_DWELL_TIME      = 2'd2,
        CFG_SEGMENTS_IN_USE = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    // first member sits in the top bits
    typedef struct packed {
        logic [4:0]         pad;
        logic signed [31:0] target_y;
        logic signed [31:0] target_x;
        logic [31:0]        seg_move_recip;
        logic [31:0]        seg_move;
        logic [31:0]        seg_start;
        logic [31:0]        time_now;
        logic [2:0]         seg_index;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]         pad;
        logic [2:0]         active_segment;
        logic [31:0]        time_echo;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } out_beat_t;

endpackage

### hw/rtl/waypoint_cubic_trajectory.sv
// waypoint_cubic_trajectory: smooth-step reference path through loaded waypoints,
// eight-stage pipeline from tick beat to position and velocity beat
// depends on wct_pkg
//
// channel   dir  payload
// s_axis    in   tdata: seg_index, time_now, seg_start, seg_move, seg_move_recip,
//                target_x, target_y; tuser: cmd
// m_axis    out  tdata: pos_x, pos_y, vel_x, vel_y, time_echo, active_segment
// cfg       in   cfg_we, cfg_index, cfg_wdata
//
// one beat per cycle unless m_axis_tready low holds a full pipeline
// the segment store is read in the second stage, so a load is seen by the next beat
// loads and ticks past the final end time give no result beat
// reset is synchronous; the segment store is not cleared
// m_axis_tready low holds the output register while bubbles behind it fill up
module waypoint_cubic_trajectory (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  wct_pkg::cfg_reg_t                   cfg_index,
    input  logic [wct_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // seg_index, time_now, seg_start, seg_move, seg_move_recip, target_x, target_y
    input  logic [wct_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, time_echo, active_segment
    output logic [wct_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import wct_pkg::*;

    typedef struct packed {
        logic [31:0]        now;
        logic signed [33:0] rel;
    } st1_t;

    typedef struct packed {
        logic [31:0]          now;
        logic [SEG_IDX_W-1:0] idx;
        logic                 hold;
        logic [31:0]          start_time;
        logic [31:0]          travel;
        logic [31:0]          recip;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
        logic signed [31:0]   ox;
        logic signed [31:0]   oy;
    } st2_t;

    typedef struct packed {
        logic [31:0]          now;
        logic [SEG_IDX_W-1:0] idx;
        logic                 hold;
        logic [31:0]          tau;
        logic [31:0]          recip;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
        logic signed [31:0]   ox;
        logic signed [31:0]   oy;
        logic signed [32:0]   dx;
        logic signed [32:0]   dy;
    } st3_t;

    typedef struct packed {
        logic [31:0]          now;
        logic [SEG_IDX_W-1:0] idx;
        logic                 hold;
        logic [31:0]          recip;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
        logic signed [31:0]   ox;
        logic signed [31:0]   oy;
        logic signed [32:0]   dx;
        logic signed [32:0]   dy;
        logic [31:0]          magx;
        logic [31:0]          magy;
        logic                 negx;
        logic                 negy;
        logic [16:0]          s;
    } st4_t;

    typedef struct packed {
        logic [31:0]          now;
        logic [SEG_IDX_W-1:0] idx;
        logic                 hold;
        logic [31:0]          recip;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
        logic signed [31:0]   ox;
        logic signed [31:0]   oy;
        logic signed [32:0]   dx;
        logic signed [32:0]   dy;
        logic [31:0]          magx;
        logic [31:0]          magy;
        logic                 negx;
        logic                 negy;
        logic [16:0]          sq;
        logic [17:0]          kf;
        logic [16:0]          g;
    } st5_t;

    typedef struct packed {
        logic [31:0]          now;
        logic [SEG_IDX_W-1:0] idx;
        logic                 hold;
        logic [31:0]          recip;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
        logic signed [31:0]   ox;
        logic signed [31:0]   oy;
        logic signed [32:0]   dx;
        logic signed [32:0]   dy;
        logic                 negx;
        logic                 negy;
        logic [16:0]          h;
        logic [32:0]          m1x;
        logic [32:0]          m1y;
    } st6_t;

    typedef struct packed {
        logic [31:0]          now;
        logic [SEG_IDX_W-1:0] idx;
        logic                 hold;
        logic signed [31:0]   ex;
        logic signed [31:0]   ey;
        logic signed [31:0]   ox;
        logic signed [31:0]   oy;
        logic                 negx;
        logic                 negy;
        logic [31:0]          offx;
        logic [31:0]          offy;
        logic [48:0]          vhix;
        logic [48:0]          vhiy;
        logic [31:0]          vlox;
        logic [31:0]          vloy;
    } st7_t;

    function automatic logic [31:0] sat_vel(input logic neg, input logic [49:0] v);
        logic [49:0] lim;
        logic [31:0] l32;
        begin
            if (neg) begin
                lim = (v > 50'h0_8000_0000) ? 50'h0_8000_0000 : v;
                l32 = lim[31:0];
                sat_vel = -l32;
            end else begin
                sat_vel = (v > 50'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
            end
        end
    endfunction

    // configuration
    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;
    logic [31:0]        dwell_reg;
    logic [3:0]         seg_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            dwell_reg     <= 32'd131072;
            seg_count_reg <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START_X:         start_x_reg   <= cfg_wdata;
                CFG_START_Y:         start_y_reg   <= cfg_wdata;
                CFG_DWELL_TIME:      dwell_reg     <= cfg_wdata;
                CFG_SEGMENTS_IN_USE: seg_count_reg <= cfg_wdata[3:0];
            endcase
        end
    end

    // handshake and stage advance
    in_beat_t                in_beat;
    logic                    in_fire;
    logic                    tick_fire;
    logic                    load_fire;
    logic [SEG_IDX_W-1:0]    load_idx;
    logic [PIPE_DEPTH-1:0]   valid_reg;
    logic [PIPE_DEPTH-1:0]   valid_next;
    logic [PIPE_DEPTH-1:0]   adv;
    logic                    keep;

    assign in_beat   = in_beat_t'(s_axis_tdata);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign tick_fire = in_fire && (cmd_t'(s_axis_tuser[0]) == CMD_TICK);
    assign load_fire = in_fire && (cmd_t'(s_axis_tuser[0]) == CMD_LOAD)
                       && (int'(in_beat.seg_index) < SEG_LIMIT);
    assign load_idx  = in_beat.seg_index[SEG_IDX_W-1:0];

    always_comb begin
        adv[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_axis_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];

    always_comb begin
        valid_next[0] = tick_fire;
        valid_next[1] = valid_reg[0] && keep;
        for (int k = 2; k < PIPE_DEPTH; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // segment store; org_*_mem[k] holds the end point of segment k-1
    logic [32:0]        end_sum_mem [SEG_LIMIT];
    logic [31:0]        start_mem   [SEG_LIMIT];
    logic [31:0]        travel_mem  [SEG_LIMIT];
    logic [31:0]        recip_mem   [SEG_LIMIT];
    logic signed [31:0] end_x_mem   [SEG_LIMIT];
    logic signed [31:0] end_y_mem   [SEG_LIMIT];
    logic signed [31:0] org_x_mem   [SEG_LIMIT];
    logic signed [31:0] org_y_mem   [SEG_LIMIT];

    always_ff @(posedge aclk) begin
        if (load_fire) begin
            end_sum_mem[load_idx] <= {1'b0, in_beat.seg_start} + {1'b0, in_beat.seg_move};
            start_mem[load_idx]   <= in_beat.seg_start;
            travel_mem[load_idx]  <= in_beat.seg_move;
            recip_mem[load_idx]   <= in_beat.seg_move_recip;
            end_x_mem[load_idx]   <= in_beat.target_x;
            end_y_mem[load_idx]   <= in_beat.target_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fire && (int'(load_idx) < SEG_LIMIT - 1)) begin
            org_x_mem[load_idx + SEG_IDX_W'(1)] <= in_beat.target_x;
            org_y_mem[load_idx + SEG_IDX_W'(1)] <= in_beat.target_y;
        end
    end

    // stage 1: time relative to dwell
    st1_t st1_reg;
    st1_t st1_next;

    always_comb begin
        st1_next.now = in_beat.time_now;
        st1_next.rel = {2'b00, in_beat.time_now} - {2'b00, dwell_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_reg <= st1_next;
        end
    end

    // stage 2: segment search and store read
    logic [SEG_IDX_W-1:0] last_idx;
    logic [SEG_IDX_W-1:0] sel_idx;
    logic [SEG_LIMIT-1:0] ahead;
    logic [SEG_LIMIT-1:0] on_end;
    logic                 found;
    logic                 at_final;
    st2_t                 st2_reg;
    st2_t                 st2_next;

    always_comb begin
        priority if (seg_count_reg == 4'd0) begin
            last_idx = '0;
        end else if (int'(seg_count_reg) > SEG_LIMIT) begin
            last_idx = SEG_IDX_W'(SEG_LIMIT - 1);
        end else begin
            last_idx = SEG_IDX_W'(seg_count_reg - 4'd1);
        end
    end

    always_comb begin
        for (int k = 0; k < SEG_LIMIT; k++) begin
            ahead[k]  = st1_reg.rel < $signed({1'b0, end_sum_mem[k]});
            on_end[k] = st1_reg.rel == $signed({1'b0, end_sum_mem[k]});
        end
        found   = 1'b0;
        sel_idx = last_idx;
        for (int k = 0; k < SEG_LIMIT; k++) begin
            if (!found && ahead[k] && (k <= int'(last_idx))) begin
                found   = 1'b1;
                sel_idx = SEG_IDX_W'(k);
            end
        end
        at_final = on_end[last_idx];
        keep     = found || at_final;
    end

    always_comb begin
        st2_next.now        = st1_reg.now;
        st2_next.idx        = sel_idx;
        st2_next.hold       = !found;
        st2_next.start_time = start_mem[sel_idx];
        st2_next.travel     = travel_mem[sel_idx];
        st2_next.recip      = recip_mem[sel_idx];
        st2_next.ex         = end_x_mem[sel_idx];
        st2_next.ey         = end_y_mem[sel_idx];
        st2_next.ox         = (sel_idx == '0) ? start_x_reg : org_x_mem[sel_idx];
        st2_next.oy         = (sel_idx == '0) ? start_y_reg : org_y_mem[sel_idx];
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            st2_reg <= st2_next;
        end
    end

    // stage 3: elapsed move time and deltas
    st3_t        st3_reg;
    st3_t        st3_next;
    logic [31:0] tau;

    always_comb begin
        tau = (st2_reg.now >= st2_reg.start_time) ? st2_reg.now - st2_reg.start_time : 32'd0;
        st3_next.now   = st2_reg.now;
        st3_next.idx   = st2_reg.idx;
        st3_next.hold  = st2_reg.hold || (tau >= st2_reg.travel);
        st3_next.tau   = tau;
        st3_next.recip = st2_reg.recip;
        st3_next.ex    = st2_reg.ex;
        st3_next.ey    = st2_reg.ey;
        st3_next.ox    = st2_reg.ox;
        st3_next.oy    = st2_reg.oy;
        st3_next.dx    = $signed({st2_reg.ex[31], st2_reg.ex})
                         - $signed({st2_reg.ox[31], st2_reg.ox});
        st3_next.dy    = $signed({st2_reg.ey[31], st2_reg.ey})
                         - $signed({st2_reg.oy[31], st2_reg.oy});
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            st3_reg <= st3_next;
        end
    end

    // stage 4: move fraction s and delta magnitudes
    st4_t        st4_reg;
    st4_t        st4_next;
    logic [63:0] s_prod;
    logic [32:0] ndx;
    logic [32:0] ndy;

    always_comb begin
        s_prod = st3_reg.tau * st3_reg.recip;
        ndx    = -st3_reg.dx;
        ndy    = -st3_reg.dy;
        st4_next.now   = st3_reg.now;
        st4_next.idx   = st3_reg.idx;
        st4_next.hold  = st3_reg.hold;
        st4_next.recip = st3_reg.recip;
        st4_next.ex    = st3_reg.ex;
        st4_next.ey    = st3_reg.ey;
        st4_next.ox    = st3_reg.ox;
        st4_next.oy    = st3_reg.oy;
        st4_next.dx    = st3_reg.dx;
        st4_next.dy    = st3_reg.dy;
        st4_next.negx  = st3_reg.dx[32];
        st4_next.negy  = st3_reg.dy[32];
        st4_next.magx  = st3_reg.dx[32] ? ndx[31:0] : st3_reg.dx[31:0];
        st4_next.magy  = st3_reg.dy[32] ? ndy[31:0] : st3_reg.dy[31:0];
        st4_next.s     = (s_prod[63:16] > 48'(S_ONE)) ? S_ONE : s_prod[32:16];
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            st4_reg <= st4_next;
        end
    end

    // stage 5: s squared, velocity shape g, blend factor
    st5_t        st5_reg;
    st5_t        st5_next;
    logic [33:0] sq_full;
    logic [33:0] q_full;
    logic [36:0] six_q;

    always_comb begin
        sq_full = st4_reg.s * st4_reg.s;
        q_full  = st4_reg.s * (S_ONE - st4_reg.s);
        six_q   = {1'b0, q_full, 2'b00} + {2'b00, q_full, 1'b0};
        st5_next.now   = st4_reg.now;
        st5_next.idx   = st4_reg.idx;
        st5_next.hold  = st4_reg.hold;
        st5_next.recip = st4_reg.recip;
        st5_next.ex    = st4_reg.ex;
        st5_next.ey    = st4_reg.ey;
        st5_next.ox    = st4_reg.ox;
        st5_next.oy    = st4_reg.oy;
        st5_next.dx    = st4_reg.dx;
        st5_next.dy    = st4_reg.dy;
        st5_next.magx  = st4_reg.magx;
        st5_next.magy  = st4_reg.magy;
        st5_next.negx  = st4_reg.negx;
        st5_next.negy  = st4_reg.negy;
        st5_next.sq    = sq_full[32:16];
        st5_next.kf    = H_THREE - {st4_reg.s, 1'b0};
        st5_next.g     = six_q[32:16];
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            st5_reg <= st5_next;
        end
    end

    // stage 6: smooth-step h and scaled delta magnitudes
    st6_t        st6_reg;
    st6_t        st6_next;
    logic [34:0] h_full;
    logic [48:0] m1x_full;
    logic [48:0] m1y_full;

    always_comb begin
        h_full   = st5_reg.sq * st5_reg.kf;
        m1x_full = st5_reg.magx * st5_reg.g;
        m1y_full = st5_reg.magy * st5_reg.g;
        st6_next.now   = st5_reg.now;
        st6_next.idx   = st5_reg.idx;
        st6_next.hold  = st5_reg.hold;
        st6_next.recip = st5_reg.recip;
        st6_next.ex    = st5_reg.ex;
        st6_next.ey    = st5_reg.ey;
        st6_next.ox    = st5_reg.ox;
        st6_next.oy    = st5_reg.oy;
        st6_next.dx    = st5_reg.dx;
        st6_next.dy    = st5_reg.dy;
        st6_next.negx  = st5_reg.negx;
        st6_next.negy  = st5_reg.negy;
        st6_next.h     = h_full[32:16];
        st6_next.m1x   = m1x_full[48:16];
        st6_next.m1y   = m1y_full[48:16];
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            st6_reg <= st6_next;
        end
    end

    // stage 7: position offsets and velocity partial products
    st7_t               st7_reg;
    st7_t               st7_next;
    logic signed [50:0] offx_full;
    logic signed [50:0] offy_full;
    logic [47:0]        vlox_full;
    logic [47:0]        vloy_full;

    always_comb begin
        offx_full = st6_reg.dx * $signed({1'b0, st6_reg.h});
        offy_full = st6_reg.dy * $signed({1'b0, st6_reg.h});
        vlox_full = st6_reg.m1x[15:0] * st6_reg.recip;
        vloy_full = st6_reg.m1y[15:0] * st6_reg.recip;
        st7_next.now  = st6_reg.now;
        st7_next.idx  = st6_reg.idx;
        st7_next.hold = st6_reg.hold;
        st7_next.ex   = st6_reg.ex;
        st7_next.ey   = st6_reg.ey;
        st7_next.ox   = st6_reg.ox;
        st7_next.oy   = st6_reg.oy;
        st7_next.negx = st6_reg.negx;
        st7_next.negy = st6_reg.negy;
        st7_next.offx = offx_full[47:16];
        st7_next.offy = offy_full[47:16];
        st7_next.vhix = st6_reg.m1x[32:16] * st6_reg.recip;
        st7_next.vhiy = st6_reg.m1y[32:16] * st6_reg.recip;
        st7_next.vlox = vlox_full[47:16];
        st7_next.vloy = vloy_full[47:16];
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            st7_reg <= st7_next;
        end
    end

    // stage 8: output register
    out_beat_t   out_reg;
    out_beat_t   out_next;
    logic [49:0] vsum_x;
    logic [49:0] vsum_y;

    always_comb begin
        vsum_x = {1'b0, st7_reg.vhix} + {18'd0, st7_reg.vlox};
        vsum_y = {1'b0, st7_reg.vhiy} + {18'd0, st7_reg.vloy};
        out_next.pad            = '0;
        out_next.active_segment = 3'(st7_reg.idx);
        out_next.time_echo      = st7_reg.now;
        if (st7_reg.hold) begin
            out_next.pos_x = st7_reg.ex;
            out_next.pos_y = st7_reg.ey;
            out_next.vel_x = '0;
            out_next.vel_y = '0;
        end else begin
            out_next.pos_x = st7_reg.ox + $signed(st7_reg.offx);
            out_next.pos_y = st7_reg.oy + $signed(st7_reg.offy);
            out_next.vel_x = sat_vel(st7_reg.negx, vsum_x);
            out_next.vel_y = sat_vel(st7_reg.negy, vsum_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = out_reg;

endmodule

### hw/rtl/wct_checker.sv
// wct_checker: port-level checks on the waypoint cubic trajectory block
// depends on wct_pkg; bound to waypoint_cubic_trajectory below
module wct_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [wct_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import wct_pkg::*;

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result beat shown right after reset");

    // a stalled result beat stays in place
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // a free output register lets the input side move
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output side free");

endmodule

bind waypoint_cubic_trajectory wct_checker u_wct_checker (.*);
